// ----- rtl/photometric_stereo_depth_integrator_top_assert.svh -----
// Assertion macros for the photometric stereo depth integrator.
`ifndef PHOTOMETRIC_STEREO_DEPTH_INTEGRATOR_TOP_ASSERT_SVH
`define PHOTOMETRIC_STEREO_DEPTH_INTEGRATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSDI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PSDI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/psdi_pkg.sv -----
// ----------------------------------------------------------------------------
// psdi_pkg
// Shared types and constants of the photometric stereo depth integrator.
// ----------------------------------------------------------------------------
package psdi_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_LIGHTS_DEF = 4;
  localparam int NUM_INTEN      = 4;
  localparam int INTEN_W        = 8;
  localparam int COEF_W         = 16;
  localparam int DEPTH_W        = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int LIGHTS_W       = 3;
  localparam int IMG_W_W        = 11;

  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PINV_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PINV_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PINV_Z      = 3'd4;

  localparam logic [LIGHTS_W-1:0] LIGHT_COUNT_RST = 3'd3;
  localparam logic [IMG_W_W-1:0]  IMAGE_WIDTH_RST = 11'd640;

  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [NUM_INTEN-1:0][INTEN_W-1:0] inten;
    logic                              first_row;
    logic                              at_col0;
  } entry_t;

endpackage

// ----- rtl/psdi_queue.sv -----
// ----------------------------------------------------------------------------
// psdi_queue
// Small FIFO between the pixel front end and the integration back end.
// ----------------------------------------------------------------------------
module psdi_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/psdi_front.sv -----
// ----------------------------------------------------------------------------
// psdi_front
// Accepts pixels, tracks raster position and classifies each pixel.
// ----------------------------------------------------------------------------
module psdi_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int COL_W     = 10
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    in_valid,
  output logic                                                    in_ready,
  input  logic [psdi_pkg::NUM_INTEN-1:0][psdi_pkg::INTEN_W-1:0]   inten,
  input  logic                                                    frame_start,
  input  logic [psdi_pkg::IMG_W_W-1:0]                            image_width,
  output logic                                                    push_valid,
  input  logic                                                    push_ready,
  output psdi_pkg::entry_t                                        push_entry,
  output logic [COL_W-1:0]                                        push_col
);

  import psdi_pkg::*;

  localparam int WW0 = $clog2(MAX_WIDTH + 1);
  localparam int WW  = (WW0 > IMG_W_W) ? WW0 : IMG_W_W;

  logic [COL_W-1:0] col_r;
  logic             first_r;
  logic [COL_W-1:0] x;
  logic             first;
  logic [WW-1:0]    w_eff, x_next;
  logic             row_end, accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  assign x     = frame_start ? '0 : col_r;
  assign first = frame_start || first_r;

  always_comb begin
    if (image_width < IMG_W_W'(2)) begin
      w_eff = WW'(2);
    end else if (WW'(image_width) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
  end

  assign x_next  = WW'(x) + 1'b1;
  assign row_end = (x_next >= w_eff);

  always_comb begin
    push_entry.inten     = inten;
    push_entry.first_row = first;
    push_entry.at_col0   = (x == '0);
    push_col             = x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      first_r <= 1'b1;
    end else if (accept) begin
      if (row_end) begin
        col_r   <= '0;
        first_r <= 1'b0;
      end else begin
        col_r   <= x_next[COL_W-1:0];
        first_r <= first;
      end
    end
  end

endmodule

// ----- rtl/psdi_back.sv -----
// ----------------------------------------------------------------------------
// psdi_back
// Forms the normal, divides by nz and integrates depth against the row store.
// ----------------------------------------------------------------------------
module psdi_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_LIGHTS = 4,
  parameter int COL_W      = 10
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    pop_valid,
  output logic                                    pop_ready,
  input  psdi_pkg::entry_t                        pop_entry,
  input  logic [COL_W-1:0]                        pop_col,
  input  logic [psdi_pkg::LIGHTS_W-1:0]           light_count,
  input  logic [psdi_pkg::CFG_DATA_W-1:0]         pinv_x,
  input  logic [psdi_pkg::CFG_DATA_W-1:0]         pinv_y,
  input  logic [psdi_pkg::CFG_DATA_W-1:0]         pinv_z,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [psdi_pkg::DEPTH_W-1:0]     out_depth,
  output logic                                    out_slope_fault
);

  import psdi_pkg::*;

  localparam int PROD_W = COEF_W + INTEN_W + 1;
  localparam int ACC_W  = PROD_W + $clog2(MAX_LIGHTS);
  localparam int NUM_W  = ACC_W + 1;
  localparam int QW     = NUM_W + 8;
  localparam int SUM_W  = QW + 2;
  localparam int CNT_W  = $clog2(QW);
  localparam int STEP_W = $clog2(NUM_INTEN);
  localparam int NL_W   = 4;

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_PREP, S_DIV, S_DONE} state_t;

  state_t                     state_r;
  entry_t                     ent_r;
  logic [COL_W-1:0]           col_r;
  logic [STEP_W-1:0]          step_r;
  logic signed [ACC_W-1:0]    acc_x_r, acc_y_r, acc_z_r;
  logic signed [DEPTH_W-1:0]  rd_q_r, disp_new_r, upright_r, disp_r, left_r, base_r;
  logic signed [DEPTH_W-1:0]  mem [MAX_WIDTH];
  logic                       num_neg_r, num_zero_r, den_neg_r, nz_zero_r;
  logic [QW-1:0]              dvd_r, quo_r;
  logic [ACC_W-1:0]           dvs_r, rem_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       out_valid_r, out_fault_r;
  logic signed [DEPTH_W-1:0]  out_depth_r;

  logic [NL_W-1:0]            nl;
  logic [COL_W-1:0]           rd_addr;
  logic [INTEN_W-1:0]         inten_sel;
  logic signed [COEF_W-1:0]   cx, cy, cz;
  logic signed [PROD_W-1:0]   px, py, pz;
  logic signed [NUM_W-1:0]    num;
  logic signed [DEPTH_W-1:0]  base;
  logic [NUM_W-1:0]           num_mag;
  logic [ACC_W-1:0]           nz_mag;
  logic [ACC_W:0]             r2;
  logic                       q_bit;
  logic signed [SUM_W-1:0]    q_s, sum;
  logic signed [DEPTH_W-1:0]  depth;
  logic                       origin, out_free;

  always_comb begin
    if (light_count < LIGHTS_W'(3)) begin
      nl = NL_W'(3);
    end else if (light_count > LIGHTS_W'(4)) begin
      nl = NL_W'(4);
    end else begin
      nl = NL_W'(light_count);
    end
    if (nl > NL_W'(MAX_LIGHTS)) begin
      nl = NL_W'(MAX_LIGHTS);
    end
  end

  assign origin    = ent_r.first_row && ent_r.at_col0;
  assign pop_ready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign rd_addr   = (state_r == S_IDLE) ? pop_col : COL_W'(1);

  assign inten_sel = ent_r.inten[step_r];
  assign cx = pinv_x[COEF_W*step_r +: COEF_W];
  assign cy = pinv_y[COEF_W*step_r +: COEF_W];
  assign cz = pinv_z[COEF_W*step_r +: COEF_W];
  assign px = cx * $signed({1'b0, inten_sel});
  assign py = cy * $signed({1'b0, inten_sel});
  assign pz = cz * $signed({1'b0, inten_sel});

  always_comb begin
    priority if (ent_r.first_row) begin
      num  = NUM_W'(acc_x_r);
      base = left_r;
    end else if (ent_r.at_col0) begin
      num  = NUM_W'(acc_y_r) - NUM_W'(acc_x_r);
      base = upright_r;
    end else begin
      num  = NUM_W'(acc_x_r) + NUM_W'(acc_y_r);
      base = disp_r;
    end
  end

  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign nz_mag  = acc_z_r[ACC_W-1] ? ACC_W'(-acc_z_r) : ACC_W'(acc_z_r);

  assign r2    = {rem_r, dvd_r[QW-1]};
  assign q_bit = (r2 >= {1'b0, dvs_r});

  always_comb begin
    q_s = $signed({2'b00, quo_r});
    if (num_neg_r ^ den_neg_r) begin
      q_s = -q_s;
    end
    sum = SUM_W'(base_r) + q_s;
    priority if (origin) begin
      depth = '0;
    end else if (nz_zero_r) begin
      if (num_zero_r) begin
        depth = base_r;
      end else if (num_neg_r) begin
        depth = DEPTH_MIN;
      end else begin
        depth = DEPTH_MAX;
      end
    end else if (sum > SUM_W'(DEPTH_MAX)) begin
      depth = DEPTH_MAX;
    end else if (sum < SUM_W'(DEPTH_MIN)) begin
      depth = DEPTH_MIN;
    end else begin
      depth = sum[DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
    if (state_r == S_DONE && (origin || out_free)) begin
      mem[col_r] <= depth;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      disp_r      <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            ent_r   <= pop_entry;
            col_r   <= pop_col;
            step_r  <= '0;
            acc_x_r <= '0;
            acc_y_r <= '0;
            acc_z_r <= '0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          acc_x_r <= acc_x_r + ACC_W'(px);
          acc_y_r <= acc_y_r + ACC_W'(py);
          acc_z_r <= acc_z_r + ACC_W'(pz);
          if (step_r == STEP_W'(0)) begin
            disp_new_r <= rd_q_r;
          end
          if (step_r == STEP_W'(1)) begin
            upright_r <= rd_q_r;
          end
          if (NL_W'(step_r) == nl - 1'b1) begin
            state_r <= S_PREP;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_PREP: begin
          base_r     <= base;
          num_neg_r  <= num[NUM_W-1];
          num_zero_r <= (num == '0);
          den_neg_r  <= acc_z_r[ACC_W-1];
          nz_zero_r  <= (acc_z_r == '0);
          dvd_r      <= {num_mag, 8'b0};
          dvs_r      <= nz_mag;
          rem_r      <= '0;
          quo_r      <= '0;
          cnt_r      <= '0;
          state_r    <= (origin || acc_z_r == '0) ? S_DONE : S_DIV;
        end
        S_DIV: begin
          rem_r <= q_bit ? ACC_W'(r2 - {1'b0, dvs_r}) : r2[ACC_W-1:0];
          quo_r <= {quo_r[QW-2:0], q_bit};
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(QW - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (origin || out_free) begin
            disp_r  <= disp_new_r;
            left_r  <= depth;
            state_r <= S_IDLE;
            if (!origin) begin
              out_valid_r <= 1'b1;
              out_depth_r <= depth;
              out_fault_r <= nz_zero_r;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_depth       = out_depth_r;
  assign out_slope_fault = out_fault_r;

endmodule

// ----- rtl/photometric_stereo_depth_integrator_top.sv -----
// ----------------------------------------------------------------------------
// photometric_stereo_depth_integrator_top
// Pixels in raster order in, integrated signed Q24.8 depth out.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one pixel: four grey levels and
// in_frame_start, which marks the upper-left pixel of a new image.
// Output channel out_valid/out_ready carries depth and slope_fault; every
// pixel gives one item except the upper-left one of a frame.
// Configuration: cfg_we writes cfg_wdata to register cfg_index at once;
// write only while the block is idle.
// The back end takes one pixel at a time through the serial normal accumulation
// (one light per cycle, 3 or 4 lights in use) and the restoring divider that
// resolves one quotient bit per cycle for a 36-bit quotient. An accepted item
// passes S_MAC, S_PREP, S_DIV and S_DONE before its result is registered at
// the output. The upper-left pixel and pixels with zero nz skip the divider.
// The front end and a two-entry queue take further pixels while the back end
// works; an output register holds a result until taken, and the back end
// waits on it when the receiver stalls.
// Synchronous reset clears position and neighbor depths and sets configuration
// to its reset values; the previous-row store holds no value until a row writes it.
// ----------------------------------------------------------------------------
module photometric_stereo_depth_integrator_top #(
  parameter int MAX_WIDTH  = psdi_pkg::MAX_WIDTH_DEF,
  parameter int MAX_LIGHTS = psdi_pkg::MAX_LIGHTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [psdi_pkg::INTEN_W-1:0]         in_intensity_0,
  input  logic [psdi_pkg::INTEN_W-1:0]         in_intensity_1,
  input  logic [psdi_pkg::INTEN_W-1:0]         in_intensity_2,
  input  logic [psdi_pkg::INTEN_W-1:0]         in_intensity_3,
  input  logic                                 in_frame_start,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [psdi_pkg::DEPTH_W-1:0]  out_depth,
  output logic                                 out_slope_fault,
  input  logic                                 cfg_we,
  input  logic [psdi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psdi_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import psdi_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int QD_W  = COL_W + $bits(entry_t);

  logic [LIGHTS_W-1:0]               light_count_r;
  logic [IMG_W_W-1:0]                image_width_r;
  logic [CFG_DATA_W-1:0]             pinv_x_r, pinv_y_r, pinv_z_r;
  logic [NUM_INTEN-1:0][INTEN_W-1:0] inten;
  logic                              push_valid, push_ready, pop_valid, pop_ready;
  entry_t                            push_entry, pop_entry;
  logic [COL_W-1:0]                  push_col, pop_col;
  logic [QD_W-1:0]                   pop_data;

  assign inten = {in_intensity_3, in_intensity_2, in_intensity_1, in_intensity_0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_count_r <= LIGHT_COUNT_RST;
      image_width_r <= IMAGE_WIDTH_RST;
      pinv_x_r      <= '0;
      pinv_y_r      <= '0;
      pinv_z_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIGHT_COUNT: light_count_r <= cfg_wdata[LIGHTS_W-1:0];
        REG_IMAGE_WIDTH: image_width_r <= cfg_wdata[IMG_W_W-1:0];
        REG_PINV_X:      pinv_x_r      <= cfg_wdata;
        REG_PINV_Y:      pinv_y_r      <= cfg_wdata;
        REG_PINV_Z:      pinv_z_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  psdi_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .inten       (inten),
    .frame_start (in_frame_start),
    .image_width (image_width_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_entry  (push_entry),
    .push_col    (push_col)
  );

  psdi_queue #(
    .W     (QD_W),
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_col, push_entry}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_col   = pop_data[QD_W-1 -: COL_W];
  assign pop_entry = entry_t'(pop_data[$bits(entry_t)-1:0]);

  psdi_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LIGHTS (MAX_LIGHTS),
    .COL_W      (COL_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_entry       (pop_entry),
    .pop_col         (pop_col),
    .light_count     (light_count_r),
    .pinv_x          (pinv_x_r),
    .pinv_y          (pinv_y_r),
    .pinv_z          (pinv_z_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_depth       (out_depth),
    .out_slope_fault (out_slope_fault)
  );

endmodule

// ----- rtl/psdi_checker.sv -----
// ----------------------------------------------------------------------------
// psdi_checker
// Port-level checks of the depth integrator, bound to the top level.
// ----------------------------------------------------------------------------
`include "photometric_stereo_depth_integrator_top_assert.svh"

module psdi_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [psdi_pkg::DEPTH_W-1:0] out_depth,
  input logic                                out_slope_fault
);

  `PSDI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `PSDI_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_depth) && $stable(out_slope_fault))
  `PSDI_ASSERT_NOW(a_reset_no_out, clk, rst_n, $past(!rst_n), !out_valid)
  `PSDI_ASSERT_NOW(a_reset_ready, clk, rst_n, $past(!rst_n), in_ready)

endmodule

bind photometric_stereo_depth_integrator_top psdi_checker u_psdi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_depth       (out_depth),
  .out_slope_fault (out_slope_fault)
);
